FILE: rtl/core/pal_pkg.sv
// ============================================================================
// pal_pkg
// Shared types, codes and constants of the polled I/O assembly register.
// ============================================================================
`default_nettype none

package pal_pkg;

    // Field widths.
    localparam int unsigned WORD_W  = 36;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned FLAGS_W = 11;

    // Characters held by one word; also the reset value of the counter.
    localparam logic [CNT_W-1:0] CHARS_PER_WORD = 3'd6;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_WR_WORD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RD_WORD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WR_CHAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RD_CHAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ATTN    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BOOT    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd6;

    // Access status codes.
    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EOR = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TE  = 2'd2;

    // Bit positions in the handshake flag vector.
    localparam int unsigned FLAG_FULL   = 0;
    localparam int unsigned FLAG_WRITE  = 1;
    localparam int unsigned FLAG_WEOR   = 2;
    localparam int unsigned FLAG_REOR   = 3;
    localparam int unsigned FLAG_DISCO  = 4;
    localparam int unsigned FLAG_ACTIVE = 5;
    localparam int unsigned FLAG_ATTN   = 6;
    localparam int unsigned FLAG_WAIT   = 7;
    localparam int unsigned FLAG_SEL    = 8;
    localparam int unsigned FLAG_START  = 9;
    localparam int unsigned FLAG_PEND   = 10;

    // One input beat.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] data_in;
        logic              req_disconnect;
        logic              req_end_seen;
        logic              req_end_write;
        logic              selected_in;
        logic              wait_in;
    } t_req;

    // One result beat.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] data_out;
        logic              io_check;
        logic              full_flag;
        logic              disconnect_flag;
        logic              attention_flag;
    } t_rsp;

    // Interface state.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [CNT_W-1:0]   cnt;
        logic [FLAGS_W-1:0] flags;
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/pal_step.sv
// ============================================================================
// pal_step
// Next-state and result logic for one access to the assembly register.
// ============================================================================
`default_nettype none

module pal_step (
    input  wire pal_pkg::t_req   i_req,
    input  wire pal_pkg::t_state i_state,
    output pal_pkg::t_state      o_state,
    output pal_pkg::t_rsp        o_rsp
);

    logic [pal_pkg::WORD_W-1:0]  w;
    logic [pal_pkg::CNT_W-1:0]   c;
    logic [pal_pkg::CNT_W-1:0]   cd;
    logic [pal_pkg::FLAGS_W-1:0] f;
    logic [pal_pkg::STAT_W-1:0]  status;
    logic [pal_pkg::WORD_W-1:0]  dout;
    logic                        ioc;

    // Counter after one character; an exhausted or bad count restarts a word.
    always_comb begin
        if (i_state.cnt == '0 || i_state.cnt > pal_pkg::CHARS_PER_WORD) begin
            cd = pal_pkg::CHARS_PER_WORD - 3'd1;
        end else begin
            cd = i_state.cnt - 3'd1;
        end
    end

    // Access decode and flag update.
    always_comb begin
        w      = i_state.word;
        c      = i_state.cnt;
        f      = i_state.flags;
        status = pal_pkg::STAT_OK;
        dout   = '0;
        ioc    = 1'b0;

        case (i_req.kind) inside
            pal_pkg::KIND_WR_WORD, pal_pkg::KIND_WR_CHAR: begin
                if (f[pal_pkg::FLAG_FULL]) begin
                    // Register still holds data the other side has not taken.
                    if (f[pal_pkg::FLAG_WEOR]) begin
                        f[pal_pkg::FLAG_REOR] = 1'b1;
                        f[pal_pkg::FLAG_WEOR] = 1'b0;
                        f[pal_pkg::FLAG_WAIT] = 1'b0;
                        status = pal_pkg::STAT_EOR;
                    end else begin
                        if (f[pal_pkg::FLAG_ACTIVE]) begin
                            f[pal_pkg::FLAG_ATTN] = 1'b1;
                            ioc = ~i_req.req_disconnect;
                        end
                        f[pal_pkg::FLAG_DISCO] = 1'b1;
                        status = pal_pkg::STAT_TE;
                    end
                end else begin
                    if (i_req.kind == pal_pkg::KIND_WR_WORD) begin
                        w = i_req.data_in;
                        c = pal_pkg::CHARS_PER_WORD;
                        f[pal_pkg::FLAG_FULL]  = 1'b1;
                        f[pal_pkg::FLAG_WRITE] = 1'b0;
                        if (i_req.req_end_seen) begin
                            f[pal_pkg::FLAG_REOR] = 1'b1;
                        end
                    end else begin
                        // Shift one character in at the low end.
                        c = cd;
                        w = {i_state.word[pal_pkg::WORD_W-pal_pkg::CHAR_W-1:0],
                             i_req.data_in[pal_pkg::CHAR_W-1:0]};
                        if (cd == '0 || i_req.req_end_seen) begin
                            f[pal_pkg::FLAG_FULL]  = 1'b1;
                            f[pal_pkg::FLAG_WRITE] = 1'b0;
                        end
                        if (i_req.req_end_seen) begin
                            f[pal_pkg::FLAG_REOR] = 1'b1;
                        end
                    end
                    if (i_req.req_end_write) begin
                        f[pal_pkg::FLAG_FULL] = 1'b0;
                        f[pal_pkg::FLAG_WEOR] = 1'b0;
                        status = pal_pkg::STAT_EOR;
                    end
                end
            end
            pal_pkg::KIND_RD_WORD, pal_pkg::KIND_RD_CHAR: begin
                if (i_req.req_end_write) begin
                    f[pal_pkg::FLAG_WEOR] = 1'b0;
                    status = pal_pkg::STAT_EOR;
                end else if (!f[pal_pkg::FLAG_FULL]) begin
                    // Nothing to read.
                    if (f[pal_pkg::FLAG_WEOR]) begin
                        f[pal_pkg::FLAG_WRITE] = 1'b1;
                        f[pal_pkg::FLAG_WEOR]  = 1'b0;
                        f[pal_pkg::FLAG_WAIT]  = 1'b0;
                        status = pal_pkg::STAT_EOR;
                    end else begin
                        if (f[pal_pkg::FLAG_ACTIVE]) begin
                            f[pal_pkg::FLAG_ATTN] = 1'b1;
                            ioc = ~i_req.req_disconnect;
                        end
                        f[pal_pkg::FLAG_DISCO] = 1'b1;
                        status = pal_pkg::STAT_TE;
                    end
                end else begin
                    if (i_req.kind == pal_pkg::KIND_RD_WORD) begin
                        dout = i_state.word;
                        c = pal_pkg::CHARS_PER_WORD;
                        f[pal_pkg::FLAG_FULL] = 1'b0;
                    end else begin
                        // Rotate the top character out and back in at the bottom.
                        c = cd;
                        dout = {{(pal_pkg::WORD_W-pal_pkg::CHAR_W){1'b0}},
                                i_state.word[pal_pkg::WORD_W-1:
                                             pal_pkg::WORD_W-pal_pkg::CHAR_W]};
                        w = {i_state.word[pal_pkg::WORD_W-pal_pkg::CHAR_W-1:0],
                             i_state.word[pal_pkg::WORD_W-1:
                                          pal_pkg::WORD_W-pal_pkg::CHAR_W]};
                        if (cd == '0) begin
                            f[pal_pkg::FLAG_FULL] = 1'b0;
                            c = pal_pkg::CHARS_PER_WORD;
                        end
                    end
                    if (i_req.req_end_seen) begin
                        f[pal_pkg::FLAG_REOR]  = 1'b1;
                        f[pal_pkg::FLAG_WRITE] = 1'b0;
                        f[pal_pkg::FLAG_FULL]  = 1'b0;
                    end else begin
                        f[pal_pkg::FLAG_WRITE] = 1'b1;
                    end
                end
            end
            pal_pkg::KIND_ATTN: begin
                if (f[pal_pkg::FLAG_ATTN]) begin
                    f[pal_pkg::FLAG_ATTN]   = 1'b0;
                    f[pal_pkg::FLAG_START]  = 1'b0;
                    f[pal_pkg::FLAG_ACTIVE] = 1'b0;
                    f[pal_pkg::FLAG_WAIT]   = 1'b0;
                    if (f[pal_pkg::FLAG_SEL]) begin
                        f[pal_pkg::FLAG_DISCO] = 1'b1;
                    end
                end
            end
            pal_pkg::KIND_BOOT: begin
                f[pal_pkg::FLAG_ACTIVE] = 1'b1;
                f[pal_pkg::FLAG_PEND]   = 1'b0;
            end
            pal_pkg::KIND_STATUS: begin
                f[pal_pkg::FLAG_SEL]  = i_req.selected_in;
                f[pal_pkg::FLAG_WAIT] = i_req.wait_in;
            end
            default: begin
                // Unused kind leaves everything as it is.
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_state.word  = w;
        o_state.cnt   = c;
        o_state.flags = f;

        o_rsp.status          = status;
        o_rsp.data_out        = dout;
        o_rsp.io_check        = ioc;
        o_rsp.full_flag       = f[pal_pkg::FLAG_FULL];
        o_rsp.disconnect_flag = f[pal_pkg::FLAG_DISCO];
        o_rsp.attention_flag  = f[pal_pkg::FLAG_ATTN];
    end

endmodule

`default_nettype wire

FILE: rtl/core/pal_obuf.sv
// ============================================================================
// pal_obuf
// Result register with a skid stage; input stalls only once the skid stage is full.
// ============================================================================
`default_nettype none

module pal_obuf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire pal_pkg::t_rsp  i_rsp,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_pop_ready,
    output pal_pkg::t_rsp       o_rsp
);

    logic          r_main_valid;
    logic          r_skid_valid;
    pal_pkg::t_rsp r_main;
    pal_pkg::t_rsp r_skid;
    logic          pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_rsp   = r_main;

    // Control: the skid stage fills only when the main register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_rsp;
            end else begin
                r_skid <= i_rsp;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/polled_io_assembly_register_core.sv
// ============================================================================
// polled_io_assembly_register_core
// Polled I/O assembly register: word and character accesses with handshake.
// ============================================================================
// Each result is registered in the output buffer ahead of the master side.
// Throughput: one beat per cycle if the skid is empty; a single state register stage.
// A stalled master side is absorbed by a one-entry skid stage.
// Reset (synchronous, active low): word zero, count six, all flags clear.
`default_nettype none

module polled_io_assembly_register_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [35:0] data_in, [36] req_disconnect, [37] req_end_seen,
    // [38] req_end_write, [39] selected_in, [40] wait_in, [47:41] zero
    input  wire [47:0]  s_tdata,
    // [2:0] kind
    input  wire [2:0]   s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [35:0] data_out, [36] io_check, [37] full_flag,
    // [38] disconnect_flag, [39] attention_flag
    output logic [39:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);

    pal_pkg::t_req   req;
    pal_pkg::t_state cur_state;
    pal_pkg::t_state n_state;
    pal_pkg::t_rsp   rsp;
    pal_pkg::t_rsp   out_rsp;
    logic            in_beat;

    logic [pal_pkg::WORD_W-1:0]  r_word;
    logic [pal_pkg::CNT_W-1:0]   r_cnt;
    logic [pal_pkg::FLAGS_W-1:0] r_flags;

    // Unpack the input beat.
    always_comb begin
        req.kind           = s_tuser;
        req.data_in        = s_tdata[35:0];
        req.req_disconnect = s_tdata[36];
        req.req_end_seen   = s_tdata[37];
        req.req_end_write  = s_tdata[38];
        req.selected_in    = s_tdata[39];
        req.wait_in        = s_tdata[40];
    end

    assign in_beat = s_tvalid && s_tready;

    always_comb begin
        cur_state.word  = r_word;
        cur_state.cnt   = r_cnt;
        cur_state.flags = r_flags;
    end

    pal_step u_step (
        .i_req   (req),
        .i_state (cur_state),
        .o_state (n_state),
        .o_rsp   (rsp)
    );

    // Interface state, updated once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_cnt   <= pal_pkg::CHARS_PER_WORD;
            r_flags <= '0;
        end else if (in_beat) begin
            r_word  <= n_state.word;
            r_cnt   <= n_state.cnt;
            r_flags <= n_state.flags;
        end
    end

    pal_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_beat),
        .i_rsp       (rsp),
        .o_ready     (s_tready),
        .o_valid     (m_tvalid),
        .i_pop_ready (m_tready),
        .o_rsp       (out_rsp)
    );

    // Pack the result beat.
    assign m_tdata = {out_rsp.attention_flag, out_rsp.disconnect_flag,
                      out_rsp.full_flag, out_rsp.io_check, out_rsp.data_out};
    assign m_tuser = out_rsp.status;

    // The character counter never holds a value above one word of characters.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pal_pkg::CHARS_PER_WORD)
        else $error("character counter out of range");

    // An I/O check is only raised together with a time error.
    a_ioc_te: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[36] |-> m_tuser == pal_pkg::STAT_TE)
        else $error("io check without time error");

    // Read data is only returned on a good access.
    a_dout_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[35:0] != '0 |-> m_tuser == pal_pkg::STAT_OK)
        else $error("data returned on a failed access");

    // A time error always leaves the interface disconnecting.
    a_te_disco: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == pal_pkg::STAT_TE |-> m_tdata[38])
        else $error("time error without disconnect");

    // Without a beat the interface state holds.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_beat |=> $stable(r_flags) && $stable(r_word) && $stable(r_cnt))
        else $error("state changed without an input beat");

endmodule

`default_nettype wire

FILE: sim/polled_io_assembly_register_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// polled_io_assembly_register_checker
// Watches both stream channels of the assembly register core, predicts each
// result from the accepted input beats and compares it field by field.
// ============================================================================

module polled_io_assembly_register_checker
    import pal_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    // [35:0] data_in, [36] req_disconnect, [37] req_end_seen,
    // [38] req_end_write, [39] selected_in, [40] wait_in, [47:41] zero
    input  wire [47:0]  i_s_tdata,
    // [2:0] kind
    input  wire [2:0]   i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    // [35:0] data_out, [36] io_check, [37] full_flag,
    // [38] disconnect_flag, [39] attention_flag
    input  wire [39:0]  i_m_tdata,
    // [1:0] status
    input  wire [1:0]   i_m_tuser,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_eor_count,
    output int          o_te_count,
    output int          o_ioc_count
);

    // Predicted interface state.
    logic [WORD_W-1:0]  asm_word;
    logic [CNT_W-1:0]   char_cnt;
    logic [FLAGS_W-1:0] hs_flags;

    // Results still owed by the block, oldest first.
    t_rsp rsp_due_q[$];

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_checked   = 0;
        o_eor_count = 0;
        o_te_count  = 0;
        o_ioc_count = 0;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH on result %0d: %s", $realtime, o_checked, what);
        o_errors = o_errors + 1;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // A time error flags attention on an active interface and raises I/O
    // check unless the device is already disconnecting.
    task automatic note_time_error(input logic disc, inout logic ioc,
                                   inout logic [STAT_W-1:0] st);
        if (hs_flags[FLAG_ACTIVE]) begin
            hs_flags[FLAG_ATTN] = 1'b1;
            if (!disc) begin
                ioc = 1'b1;
            end
        end
        hs_flags[FLAG_DISCO] = 1'b1;
        st = STAT_TE;
    endtask

    // Step the character counter; an exhausted count starts a new word.
    function automatic logic [CNT_W-1:0] next_char_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = c;
        if (n == 0 || n > CHARS_PER_WORD) begin
            n = CHARS_PER_WORD;
        end
        return n - 1'b1;
    endfunction

    // Work out the result of one accepted beat and advance the state.
    task automatic predict_access(input t_req rq, output t_rsp rs);
        logic [STAT_W-1:0] st;
        logic [WORD_W-1:0] dout;
        logic              ioc;
        st   = STAT_OK;
        dout = '0;
        ioc  = 1'b0;
        case (rq.kind)
            KIND_WR_WORD, KIND_WR_CHAR: begin
                if (hs_flags[FLAG_FULL]) begin
                    if (hs_flags[FLAG_WEOR]) begin
                        hs_flags[FLAG_REOR] = 1'b1;
                        hs_flags[FLAG_WEOR] = 1'b0;
                        hs_flags[FLAG_WAIT] = 1'b0;
                        st = STAT_EOR;
                    end else begin
                        note_time_error(rq.req_disconnect, ioc, st);
                    end
                end else begin
                    if (rq.kind == KIND_WR_WORD) begin
                        asm_word = rq.data_in;
                        char_cnt = CHARS_PER_WORD;
                        hs_flags[FLAG_FULL]  = 1'b1;
                        hs_flags[FLAG_WRITE] = 1'b0;
                        if (rq.req_end_seen) begin
                            hs_flags[FLAG_REOR] = 1'b1;
                        end
                    end else begin
                        char_cnt = next_char_count(char_cnt);
                        asm_word = {asm_word[WORD_W-CHAR_W-1:0], rq.data_in[CHAR_W-1:0]};
                        if (char_cnt == 0 || rq.req_end_seen) begin
                            hs_flags[FLAG_FULL]  = 1'b1;
                            hs_flags[FLAG_WRITE] = 1'b0;
                        end
                        if (rq.req_end_seen) begin
                            hs_flags[FLAG_REOR] = 1'b1;
                        end
                    end
                    if (rq.req_end_write) begin
                        hs_flags[FLAG_FULL] = 1'b0;
                        hs_flags[FLAG_WEOR] = 1'b0;
                        st = STAT_EOR;
                    end
                end
            end
            KIND_RD_WORD, KIND_RD_CHAR: begin
                if (rq.req_end_write) begin
                    hs_flags[FLAG_WEOR] = 1'b0;
                    st = STAT_EOR;
                end else if (!hs_flags[FLAG_FULL]) begin
                    if (hs_flags[FLAG_WEOR]) begin
                        hs_flags[FLAG_WRITE] = 1'b1;
                        hs_flags[FLAG_WEOR]  = 1'b0;
                        hs_flags[FLAG_WAIT]  = 1'b0;
                        st = STAT_EOR;
                    end else begin
                        note_time_error(rq.req_disconnect, ioc, st);
                    end
                end else begin
                    if (rq.kind == KIND_RD_WORD) begin
                        dout     = asm_word;
                        char_cnt = CHARS_PER_WORD;
                        hs_flags[FLAG_FULL] = 1'b0;
                    end else begin
                        // Rotate the top character out and back into the bottom.
                        char_cnt = next_char_count(char_cnt);
                        dout     = {{(WORD_W-CHAR_W){1'b0}}, asm_word[WORD_W-1 -: CHAR_W]};
                        asm_word = {asm_word[WORD_W-CHAR_W-1:0], asm_word[WORD_W-1 -: CHAR_W]};
                        if (char_cnt == 0) begin
                            hs_flags[FLAG_FULL] = 1'b0;
                            char_cnt = CHARS_PER_WORD;
                        end
                    end
                    if (rq.req_end_seen) begin
                        hs_flags[FLAG_REOR]  = 1'b1;
                        hs_flags[FLAG_WRITE] = 1'b0;
                        hs_flags[FLAG_FULL]  = 1'b0;
                    end else begin
                        hs_flags[FLAG_WRITE] = 1'b1;
                    end
                end
            end
            KIND_ATTN: begin
                if (hs_flags[FLAG_ATTN]) begin
                    hs_flags[FLAG_ATTN]   = 1'b0;
                    hs_flags[FLAG_START]  = 1'b0;
                    hs_flags[FLAG_ACTIVE] = 1'b0;
                    hs_flags[FLAG_WAIT]   = 1'b0;
                    if (hs_flags[FLAG_SEL]) begin
                        hs_flags[FLAG_DISCO] = 1'b1;
                    end
                end
            end
            KIND_BOOT: begin
                hs_flags[FLAG_ACTIVE] = 1'b1;
                hs_flags[FLAG_PEND]   = 1'b0;
            end
            KIND_STATUS: begin
                hs_flags[FLAG_SEL]  = rq.selected_in;
                hs_flags[FLAG_WAIT] = rq.wait_in;
            end
            default: begin
                // The unused kind leaves everything as it was.
            end
        endcase
        rs.status          = st;
        rs.data_out        = dout;
        rs.io_check        = ioc;
        rs.full_flag       = hs_flags[FLAG_FULL];
        rs.disconnect_flag = hs_flags[FLAG_DISCO];
        rs.attention_flag  = hs_flags[FLAG_ATTN];
    endtask

    // Compare results first, then queue the prediction for this edge's input
    // beat; a result never leaves in the cycle its input is taken.
    always @(posedge i_clk) begin
        t_req req;
        t_rsp want;
        if (!i_rst_n) begin
            asm_word = '0;
            char_cnt = CHARS_PER_WORD;
            hs_flags = '0;
            rsp_due_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (rsp_due_q.size() == 0) begin
                    report_mismatch("result beat with no prediction waiting");
                end else begin
                    want = rsp_due_q.pop_front();
                    check_field("status", WORD_W'(i_m_tuser), WORD_W'(want.status));
                    check_field("data_out", i_m_tdata[35:0], want.data_out);
                    check_field("io_check", WORD_W'(i_m_tdata[36]), WORD_W'(want.io_check));
                    check_field("full_flag", WORD_W'(i_m_tdata[37]), WORD_W'(want.full_flag));
                    check_field("disconnect_flag", WORD_W'(i_m_tdata[38]),
                                WORD_W'(want.disconnect_flag));
                    check_field("attention_flag", WORD_W'(i_m_tdata[39]),
                                WORD_W'(want.attention_flag));
                    if (want.status == STAT_EOR) o_eor_count = o_eor_count + 1;
                    if (want.status == STAT_TE)  o_te_count  = o_te_count + 1;
                    if (want.io_check)           o_ioc_count = o_ioc_count + 1;
                end
                o_checked = o_checked + 1;
            end
            if (i_s_tvalid && i_s_tready) begin
                req.kind           = i_s_tuser;
                req.data_in        = i_s_tdata[35:0];
                req.req_disconnect = i_s_tdata[36];
                req.req_end_seen   = i_s_tdata[37];
                req.req_end_write  = i_s_tdata[38];
                req.selected_in    = i_s_tdata[39];
                req.wait_in        = i_s_tdata[40];
                predict_access(req, want);
                rsp_due_q.push_back(want);
            end
        end
        o_pending <= rsp_due_q.size();
    end

endmodule

FILE: sim/polled_io_assembly_register_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// polled_io_assembly_register_core_tb
// Drives word and character transfers, attention, boot and status beats into
// the assembly register core under random stalls on both sides; the checker
// beside the block predicts and compares every result.
// ============================================================================

module polled_io_assembly_register_core_tb;
    import pal_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_ITEMS  = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    // Kind code that the block does not use.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [35:0] data_in, [36] req_disconnect, [37] req_end_seen,
    // [38] req_end_write, [39] selected_in, [40] wait_in, [47:41] zero
    logic [47:0] s_tdata  = '0;
    // [2:0] kind
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [35:0] data_out, [36] io_check, [37] full_flag,
    // [38] disconnect_flag, [39] attention_flag
    logic [39:0] m_tdata;
    // [1:0] status
    logic [1:0]  m_tuser;

    int errors, pending, checked, eor_count, te_count, ioc_count;
    int sent        = 0;
    int cycle_count = 0;
    bit quiet       = 1'b0;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;

    polled_io_assembly_register_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    polled_io_assembly_register_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_eor_count (eor_count),
        .o_te_count  (te_count),
        .o_ioc_count (ioc_count)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off, and no stalls at the end.
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'({$urandom, $urandom});
    endfunction

    function automatic bit rare();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Offer one beat, with an occasional idle gap first, and wait for it to
    // be taken.
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] data,
                             input logic disc, input logic eseen, input logic ewrite,
                             input logic sel, input logic wt);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, wt, sel, ewrite, eseen, disc, data};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent = sent + 1;
    endtask

    // A beat with random content and rare end-of-record requests.
    task automatic send_access(input logic [KIND_W-1:0] kind);
        send_beat(kind, rand_word(), 1'($urandom_range(0, 1)), rare(), rare(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int total;
        int pick;
        int n;
        total = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: time errors inactive and active, attention, full-register
        // collision, extreme data, character shifting and rotation, end of
        // record, the unused kind.
        send_beat(KIND_RD_WORD, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_BOOT,    '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_RD_CHAR, '1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_beat(KIND_RD_WORD, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_STATUS,  '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_beat(KIND_ATTN,    '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_ATTN,    '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_WORD, '1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_WORD, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_RD_WORD, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_WORD, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_RD_WORD, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'hFFFFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'hFFFFFFFC0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'h00000002A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'h000000015, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'h00000003F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'h000000001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // The count is exhausted here, so this read starts a fresh word.
        send_beat(KIND_RD_CHAR, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_RD_CHAR, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_RD_CHAR, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_RD_WORD, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'h00000002B, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_RD_CHAR, '0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_beat(KIND_RD_WORD, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_WR_CHAR, 36'h000000011, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_beat(KIND_UNUSED,  '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_beat(KIND_STATUS,  '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        // Random: mostly complete transfers, some control traffic and noise.
        total   = sent + RANDOM_ITEMS;
        hold_go = 1'b1;
        while (sent < total) begin
            quiet = (sent >= total - QUIET_ITEMS);
            pick  = $urandom_range(0, 99);
            if (pick < 30) begin
                send_access(KIND_WR_WORD);
                send_access(KIND_RD_WORD);
            end else if (pick < 65) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 6;
                repeat (n) send_access(KIND_WR_CHAR);
                repeat (n) send_access(KIND_RD_CHAR);
                if ($urandom_range(0, 3) == 0) begin
                    send_access(KIND_RD_WORD);
                end
            end else if (pick < 80) begin
                // Active interface: provoke time errors, then clear attention.
                send_access(KIND_BOOT);
                repeat ($urandom_range(1, 3)) begin
                    send_access(KIND_W'(KIND_RD_WORD + 2 * $urandom_range(0, 1)));
                end
                if ($urandom_range(0, 3) != 0) begin
                    send_access(KIND_ATTN);
                end
            end else if (pick < 88) begin
                send_access(KIND_STATUS);
                if ($urandom_range(0, 1) == 0) begin
                    send_access(KIND_ATTN);
                end
            end else begin
                repeat ($urandom_range(1, 3)) send_access(KIND_W'($urandom_range(0, 7)));
            end
        end

        // Drain: let the last predictions land, then wait out the pipeline.
        s_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Covered %0d beats and %0d checked results in %0d cycles.",
                 sent, checked, cycle_count);
        $display("Results included %0d end-of-record, %0d time-error, %0d I/O check.",
                 eor_count, te_count, ioc_count);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: polled_io_assembly_register_core.f
rtl/core/pal_pkg.sv
rtl/core/pal_step.sv
rtl/core/pal_obuf.sv
rtl/core/polled_io_assembly_register_core.sv
sim/polled_io_assembly_register_checker.sv
sim/polled_io_assembly_register_core_tb.sv
